[src/knps_pkg.sv]
package knps_pkg;

   // Default sizes of the top level.
   localparam int SAMPLE_WIDTH_DEFAULT  = 16;
   localparam int INDEX_WIDTH_DEFAULT   = 10;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   // Fixed widths.
   localparam int STEP_WIDTH      = 16;
   localparam int GAIN_WIDTH      = 32;
   localparam int GRID_WIDTH      = 11;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int PHASE_WIDTH     = 32;

   // CORDIC datapath widths: x/y carry 39 - SAMPLE_WIDTH guard bits, z is the residual angle.
   localparam int CORDIC_WIDTH = 42;
   localparam int ANGLE_WIDTH  = 34;
   localparam int ATAN_COUNT   = 24;
   localparam int GUARD_TOTAL  = 39;

   // 1/K in Q0.31.
   localparam logic [31:0] INV_GAIN_Q31 = 32'd1304065748;

   localparam logic [GRID_WIDTH-1:0] GRID_RESET = 11'd1024;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PHASE_GAIN  = 2'd0,
      CSR_GRID_WIDTH  = 2'd1,
      CSR_GRID_HEIGHT = 2'd2
   } csr_index_type;

   // atan(2^-i) / (2*pi) in Q0.32 turns.
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

[src/kerr_nonlinear_phase_step_top.sv]
// Channel | Direction | Handshake           | Beat contents
// req     | in        | req_valid/req_stall | sample_re, sample_im, col_index, row_index, step_number
// rsp     | out       | rsp_valid/rsp_stall | rotated_re, rotated_im, intensity, is_centre, log_step
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One beat per cycle in and out while no result is stalled. The pipeline registers, in order:
// squares and 1/K scaling, intensity sum, two gain partial products, phase assembly, quadrant
// fold, the CORDIC stages, then rounding and saturation into the output register.
// Synchronous reset empties the pipeline and loads phase_gain 0, grid sizes 1024.
// A stalled result freezes the whole pipeline; req_stall follows it in the same cycle.
module kerr_nonlinear_phase_step_top #(
   parameter int SAMPLE_WIDTH  = knps_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH   = knps_pkg::INDEX_WIDTH_DEFAULT,
   parameter int CORDIC_STAGES = knps_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample_im,
   input  logic        [INDEX_WIDTH-1:0]           req_col_index,
   input  logic        [INDEX_WIDTH-1:0]           req_row_index,
   input  logic        [knps_pkg::STEP_WIDTH-1:0]  req_step_number,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_rotated_re,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_rotated_im,
   output logic        [2*SAMPLE_WIDTH-1:0]        rsp_intensity,
   output logic                                    rsp_is_centre,
   output logic        [knps_pkg::STEP_WIDTH-1:0]  rsp_log_step,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [knps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [knps_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int IW   = INDEX_WIDTH;
   localparam int STW  = knps_pkg::STEP_WIDTH;
   localparam int GW   = knps_pkg::GAIN_WIDTH;
   localparam int GRW  = knps_pkg::GRID_WIDTH;
   localparam int CW   = knps_pkg::CORDIC_WIDTH;
   localparam int ZW   = knps_pkg::ANGLE_WIDTH;
   localparam int PHW  = knps_pkg::PHASE_WIDTH;
   localparam int IN2W = 2 * SW;
   localparam int PW   = SW + 34;
   localparam int PPW  = SW + GW;
   localparam int SUMW = 2 * SW + GW;
   localparam int FRAC = 2 * SW - 4;
   localparam int GUARD = knps_pkg::GUARD_TOTAL - SW;
   localparam int CMPW = (IW > GRW - 1) ? IW : GRW - 1;
   localparam int TAGW = IN2W + 1 + STW;

   localparam logic signed [PW-1:0] INV_GAIN = PW'(knps_pkg::INV_GAIN_Q31);
   localparam logic signed [CW-1:0] ROUND    = CW'(1) << (GUARD - 1);
   localparam logic signed [CW-1:0] SAT_HI   = (CW'(1) << (SW - 1)) - CW'(1);
   localparam logic signed [CW-1:0] SAT_LO   = ~SAT_HI;

   // Configuration registers.
   logic [GW-1:0]  gain_ff;
   logic [GRW-1:0] grid_w_ff;
   logic [GRW-1:0] grid_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         grid_w_ff <= knps_pkg::GRID_RESET;
         grid_h_ff <= knps_pkg::GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            knps_pkg::CSR_PHASE_GAIN:  gain_ff   <= csr_data[GW-1:0];
            knps_pkg::CSR_GRID_WIDTH:  grid_w_ff <= csr_data[GRW-1:0];
            knps_pkg::CSR_GRID_HEIGHT: grid_h_ff <= csr_data[GRW-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   // Advance everything unless the output beat is held.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: squares, 1/K scaling, centre compare.
   logic                   v1_ff;
   logic signed [IN2W-1:0] sq_re1_ff, sq_im1_ff;
   logic signed [PW-1:0]   xp1_ff, yp1_ff;
   logic                   centre1_ff;
   logic [STW-1:0]         step1_ff;
   logic                   centre1_in;

   assign centre1_in = (CMPW'(req_col_index) == CMPW'(grid_w_ff[GRW-1:1]))
                    && (CMPW'(req_row_index) == CMPW'(grid_h_ff[GRW-1:1]));

   // Stage 2: intensity, pre-scaled x/y.
   logic                   v2_ff;
   logic [IN2W-1:0]        inten2_ff;
   logic signed [CW-1:0]   x2_ff, y2_ff;
   logic                   centre2_ff;
   logic [STW-1:0]         step2_ff;
   logic signed [PW-1:0]   xsh2_in, ysh2_in;

   assign xsh2_in = xp1_ff >>> (SW - 8);
   assign ysh2_in = yp1_ff >>> (SW - 8);

   // Stage 3: gain partial products.
   logic                   v3_ff;
   logic [PPW-1:0]         plo3_ff, phi3_ff;
   logic [IN2W-1:0]        inten3_ff;
   logic signed [CW-1:0]   x3_ff, y3_ff;
   logic                   centre3_ff;
   logic [STW-1:0]         step3_ff;

   // Stage 4: phase in turns.
   logic                   v4_ff;
   logic [PHW-1:0]         phase4_ff;
   logic [IN2W-1:0]        inten4_ff;
   logic signed [CW-1:0]   x4_ff, y4_ff;
   logic                   centre4_ff;
   logic [STW-1:0]         step4_ff;
   logic [SUMW-1:0]        psum4_in;

   assign psum4_in = {phi3_ff, SW'(0)} + SUMW'(plo3_ff);

   // Stage 5: quadrant fold.
   logic                   v5_ff;
   logic signed [CW-1:0]   x5_ff, y5_ff;
   logic signed [ZW-1:0]   z5_ff;
   logic [TAGW-1:0]        tag5_ff;
   logic [PHW-1:0]         qsum5;
   logic [1:0]             quad5;
   logic [PHW-1:0]         resid5;
   logic signed [CW-1:0]   x5_in, y5_in;

   assign qsum5  = phase4_ff + (PHW'(1) << (PHW - 3));
   assign quad5  = qsum5[PHW-1:PHW-2];
   assign resid5 = phase4_ff - {quad5, (PHW - 2)'(0)};

   always_comb begin
      case (quad5)
         2'd1: begin
            x5_in = -y4_ff;
            y5_in = x4_ff;
         end
         2'd2: begin
            x5_in = -x4_ff;
            y5_in = -y4_ff;
         end
         2'd3: begin
            x5_in = y4_ff;
            y5_in = -x4_ff;
         end
         default: begin
            x5_in = x4_ff;
            y5_in = y4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_re1_ff  <= req_sample_re * req_sample_re;
         sq_im1_ff  <= req_sample_im * req_sample_im;
         xp1_ff     <= PW'(req_sample_re) * INV_GAIN;
         yp1_ff     <= PW'(req_sample_im) * INV_GAIN;
         centre1_ff <= centre1_in;
         step1_ff   <= req_step_number;

         inten2_ff  <= IN2W'($unsigned(sq_re1_ff)) + IN2W'($unsigned(sq_im1_ff));
         x2_ff      <= xsh2_in[CW-1:0];
         y2_ff      <= ysh2_in[CW-1:0];
         centre2_ff <= centre1_ff;
         step2_ff   <= step1_ff;

         plo3_ff    <= PPW'(inten2_ff[SW-1:0]) * PPW'(gain_ff);
         phi3_ff    <= PPW'(inten2_ff[IN2W-1:SW]) * PPW'(gain_ff);
         inten3_ff  <= inten2_ff;
         x3_ff      <= x2_ff;
         y3_ff      <= y2_ff;
         centre3_ff <= centre2_ff;
         step3_ff   <= step2_ff;

         phase4_ff  <= psum4_in[FRAC+PHW-1:FRAC];
         inten4_ff  <= inten3_ff;
         x4_ff      <= x3_ff;
         y4_ff      <= y3_ff;
         centre4_ff <= centre3_ff;
         step4_ff   <= step3_ff;

         x5_ff      <= x5_in;
         y5_ff      <= y5_in;
         z5_ff      <= ZW'($signed(resid5));
         tag5_ff    <= {inten4_ff, centre4_ff, step4_ff};
      end
   end

   logic                 cv;
   logic signed [CW-1:0] cx, cy;
   logic [TAGW-1:0]      ctag;

   knps_cordic #(
      .STAGES    (CORDIC_STAGES),
      .TAG_WIDTH (TAGW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .src_valid (v5_ff),
      .src_x     (x5_ff),
      .src_y     (y5_ff),
      .src_z     (z5_ff),
      .src_tag   (tag5_ff),
      .dst_valid (cv),
      .dst_x     (cx),
      .dst_y     (cy),
      .dst_tag   (ctag)
   );

   // Round off guard bits and saturate.
   logic signed [CW-1:0] rx, ry;
   logic signed [SW-1:0] sat_x_in, sat_y_in;

   assign rx = (cx + ROUND) >>> GUARD;
   assign ry = (cy + ROUND) >>> GUARD;

   always_comb begin
      if (rx > SAT_HI) begin
         sat_x_in = SAT_HI[SW-1:0];
      end else if (rx < SAT_LO) begin
         sat_x_in = SAT_LO[SW-1:0];
      end else begin
         sat_x_in = rx[SW-1:0];
      end
      if (ry > SAT_HI) begin
         sat_y_in = SAT_HI[SW-1:0];
      end else if (ry < SAT_LO) begin
         sat_y_in = SAT_LO[SW-1:0];
      end else begin
         sat_y_in = ry[SW-1:0];
      end
   end

   logic signed [SW-1:0] rot_re_ff, rot_im_ff;
   logic [IN2W-1:0]      inten_ff;
   logic                 centre_ff;
   logic [STW-1:0]       step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_re_ff <= sat_x_in;
         rot_im_ff <= sat_y_in;
         inten_ff  <= ctag[TAGW-1:STW+1];
         centre_ff <= ctag[STW];
         step_ff   <= ctag[STW-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rotated_re = rot_re_ff;
   assign rsp_rotated_im = rot_im_ff;
   assign rsp_intensity  = inten_ff;
   assign rsp_is_centre  = centre_ff;
   assign rsp_log_step   = step_ff;

   // Pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Sum of two squares never exceeds the most negative sample squared times two.
   a_inten_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_intensity <= (IN2W'(1) << (IN2W - 1)))
      else $error("intensity out of range");

   // A zero sample stays zero through scaling, rotation and rounding.
   a_zero_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_intensity == '0 |-> rsp_rotated_re == '0 && rsp_rotated_im == '0)
      else $error("zero sample rotated to nonzero");

endmodule

[src/knps_cordic.sv]
module knps_cordic #(
   parameter int STAGES    = knps_pkg::CORDIC_STAGES_DEFAULT,
   parameter int TAG_WIDTH = 49
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        src_valid,
   input  logic signed [knps_pkg::CORDIC_WIDTH-1:0]    src_x,
   input  logic signed [knps_pkg::CORDIC_WIDTH-1:0]    src_y,
   input  logic signed [knps_pkg::ANGLE_WIDTH-1:0]     src_z,
   input  logic        [TAG_WIDTH-1:0]                 src_tag,
   output logic                                        dst_valid,
   output logic signed [knps_pkg::CORDIC_WIDTH-1:0]    dst_x,
   output logic signed [knps_pkg::CORDIC_WIDTH-1:0]    dst_y,
   output logic        [TAG_WIDTH-1:0]                 dst_tag
);

   localparam int NS = (STAGES < knps_pkg::ATAN_COUNT) ? STAGES : knps_pkg::ATAN_COUNT;
   localparam int CW = knps_pkg::CORDIC_WIDTH;
   localparam int ZW = knps_pkg::ANGLE_WIDTH;

   logic                 v_ff   [NS];
   logic signed [CW-1:0] x_ff   [NS];
   logic signed [CW-1:0] y_ff   [NS];
   logic signed [ZW-1:0] z_ff   [NS];
   logic [TAG_WIDTH-1:0] tag_ff [NS];
   logic signed [CW-1:0] x_in   [NS];
   logic signed [CW-1:0] y_in   [NS];
   logic signed [ZW-1:0] z_in   [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_Z = ZW'(knps_pkg::atan_turns(i));
      logic                 v_prev;
      logic signed [CW-1:0] x_prev;
      logic signed [CW-1:0] y_prev;
      logic signed [ZW-1:0] z_prev;
      logic [TAG_WIDTH-1:0] tag_prev;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;

      if (i == 0) begin : g_first
         assign v_prev   = src_valid;
         assign x_prev   = src_x;
         assign y_prev   = src_y;
         assign z_prev   = src_z;
         assign tag_prev = src_tag;
      end else begin : g_next
         assign v_prev   = v_ff[i-1];
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      assign xs = x_prev >>> i;
      assign ys = y_prev >>> i;

      // Rotate toward zero residual: positive when z >= 0.
      assign x_in[i] = z_prev[ZW-1] ? x_prev + ys : x_prev - ys;
      assign y_in[i] = z_prev[ZW-1] ? y_prev - xs : y_prev + xs;
      assign z_in[i] = z_prev[ZW-1] ? z_prev + ATAN_Z : z_prev - ATAN_Z;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            z_ff[i]   <= z_in[i];
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign dst_valid = v_ff[NS-1];
   assign dst_x     = x_ff[NS-1];
   assign dst_y     = y_ff[NS-1];
   assign dst_tag   = tag_ff[NS-1];

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int SW      = knps_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam int IW      = knps_pkg::INDEX_WIDTH_DEFAULT;
   localparam int STW     = knps_pkg::STEP_WIDTH;
   localparam int GNW     = knps_pkg::GAIN_WIDTH;
   localparam int GRW     = knps_pkg::GRID_WIDTH;
   localparam int CIW     = knps_pkg::CSR_INDEX_WIDTH;
   localparam int CDW     = knps_pkg::CSR_DATA_WIDTH;
   localparam int PHW     = knps_pkg::PHASE_WIDTH;
   localparam int STAGES  = (knps_pkg::CORDIC_STAGES_DEFAULT < 24) ?
                            knps_pkg::CORDIC_STAGES_DEFAULT : 24;
   localparam int LATENCY = 6 + STAGES;
   localparam int FRAC    = 2 * SW - 4;
   localparam int GUARD   = 39 - SW;
   localparam int PHASE_ITEMS = 144;
   localparam logic [CIW-1:0] CSR_SPARE = 2'd3;

   // atan(2^-i) in Q0.32 turns, entry 0 in the top word
   localparam logic [24*32-1:0] ATAN_TURNS = {
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [SW-1:0]  re;
      logic [SW-1:0]  im;
      logic [IW-1:0]  col;
      logic [IW-1:0]  row;
      logic [STW-1:0] step;
   } field_sample_type;

   typedef struct packed {
      logic [SW-1:0]   re;
      logic [SW-1:0]   im;
      logic [2*SW-1:0] inten;
      logic            centre;
      logic [STW-1:0]  step;
   } rotated_sample_type;

   typedef struct packed {
      logic [GNW-1:0]     gain;
      logic [GRW-1:0]     width;
      logic [GRW-1:0]     height;
      field_sample_type   item;
      logic               typed;
      rotated_sample_type result;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SW-1:0]         req_sample_re;
   logic [SW-1:0]         req_sample_im;
   logic [IW-1:0]         req_col_index;
   logic [IW-1:0]         req_row_index;
   logic [STW-1:0]        req_step_number;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [SW-1:0]  rsp_rotated_re;
   logic signed [SW-1:0]  rsp_rotated_im;
   logic [2*SW-1:0]       rsp_intensity;
   logic                  rsp_is_centre;
   logic [STW-1:0]        rsp_log_step;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CIW-1:0]        csr_index;
   logic [CDW-1:0]        csr_data;

   logic [GNW-1:0] cfg_gain;
   logic [GRW-1:0] cfg_width;
   logic [GRW-1:0] cfg_height;

   rotated_sample_type pending[$];
   rotated_sample_type head_result;
   directed_row_type   rows[$];
   int errors;
   int sent;
   int checked;
   int centre_hits;
   int settings;
   int calm_items;
   int stall_left;
   bit stall_hold;

   kerr_nonlinear_phase_step_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .req_col_index   (req_col_index),
      .req_row_index   (req_row_index),
      .req_step_number (req_step_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rotated_re  (rsp_rotated_re),
      .rsp_rotated_im  (rsp_rotated_im),
      .rsp_intensity   (rsp_intensity),
      .rsp_is_centre   (rsp_is_centre),
      .rsp_log_step    (rsp_log_step),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SW-1:0] round_saturate(input longint v);
      longint r;
      longint top;
      top = (longint'(1) <<< (SW - 1)) - 1;
      r = (v + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
      if (r > top) r = top;
      if (r < -top - 1) r = -top - 1;
      return SW'(r);
   endfunction

   function automatic rotated_sample_type predict_rotation(input field_sample_type s);
      longint re, im, x, y, z, t, xs, ys, turn;
      logic [63:0] prod;
      logic [PHW-1:0] p, folded, d;
      logic [1:0] quad;
      rotated_sample_type o;
      re = longint'($signed(s.re));
      im = longint'($signed(s.im));
      o.inten = (2*SW)'(re * re + im * im);
      prod = {32'd0, o.inten} * {32'd0, cfg_gain};
      p = 32'(prod >> FRAC);
      // fold the nearest quarter turn out, leave a signed residual
      folded = p + 32'h2000_0000;
      quad = folded[31:30];
      d = p - {quad, 30'd0};
      z = longint'($signed(d));
      x = (re * longint'(knps_pkg::INV_GAIN_Q31)) >>> (SW - 8);
      y = (im * longint'(knps_pkg::INV_GAIN_Q31)) >>> (SW - 8);
      case (quad)
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         turn = longint'(ATAN_TURNS[(23 - i)*32 +: 32]);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - turn;
         end else begin
            x = x + ys; y = y - xs; z = z + turn;
         end
      end
      o.re = round_saturate(x);
      o.im = round_saturate(y);
      o.centre = (s.col == cfg_width[GRW-1:1]) && (s.row == cfg_height[GRW-1:1]);
      o.step = s.step;
      return o;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SW-1:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic field_sample_type random_sample();
      field_sample_type s;
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         5: begin
            s.re = extreme_value();
            s.im = extreme_value();
         end
         6, 7: begin
            s.re = SW'(int'($urandom_range(0, 4095)) - 2048);
            s.im = SW'(int'($urandom_range(0, 4095)) - 2048);
         end
         8, 9: begin
            // near unit magnitude, phase tracks the gain directly
            s.re = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
            s.im = SW'(int'($urandom_range(0, 511)) - 256);
         end
         default: begin
            s.re = SW'($urandom);
            s.im = SW'($urandom);
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         s.col = cfg_width[GRW-1:1];
         s.row = cfg_height[GRW-1:1];
      end else begin
         s.col = IW'($urandom);
         s.row = IW'($urandom);
      end
      s.step = STW'($urandom);
      return s;
   endfunction

   task automatic send_sample(input field_sample_type s, input rotated_sample_type want);
      int gap;
      req_valid       <= 1'b1;
      req_sample_re   <= s.re;
      req_sample_im   <= s.im;
      req_col_index   <= s.col;
      req_row_index   <= s.row;
      req_step_number <= s.step;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending.push_back(want);
      sent++;
      if (calm_items > 0) begin
         calm_items--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) calm_items = $urandom_range(40, 160);
         gap = idle_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CIW-1:0] idx,
                            input logic [CDW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         knps_pkg::CSR_PHASE_GAIN:  cfg_gain   = data;
         knps_pkg::CSR_GRID_WIDTH:  cfg_width  = data[GRW-1:0];
         knps_pkg::CSR_GRID_HEIGHT: cfg_height = data[GRW-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [GNW-1:0] gain,
                               input logic [GRW-1:0] w,
                               input logic [GRW-1:0] h,
                               input bit noisy);
      logic [CDW-GRW-1:0] hi;
      drain();
      hi = noisy ? (CDW-GRW)'($urandom) : '0;
      write_reg(knps_pkg::CSR_PHASE_GAIN, gain);
      write_reg(knps_pkg::CSR_GRID_WIDTH, {hi, w});
      write_reg(knps_pkg::CSR_GRID_HEIGHT, {~hi, h});
      if (noisy) write_reg(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: result beat with nothing outstanding, re %0d im %0d",
                     $time, rsp_rotated_re, rsp_rotated_im);
         end else begin
            head_result = pending.pop_front();
            check_field("rotated_re", longint'($signed(head_result.re)), longint'(rsp_rotated_re));
            check_field("rotated_im", longint'($signed(head_result.im)), longint'(rsp_rotated_im));
            check_field("intensity", longint'(head_result.inten), longint'(rsp_intensity));
            check_field("is_centre", longint'(head_result.centre), longint'(rsp_is_centre));
            check_field("log_step", longint'(head_result.step), longint'(rsp_log_step));
            checked++;
            if (rsp_is_centre) centre_hits++;
         end
      end
   end

   // result side back-pressure: alternate busy and stalled runs
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      stall_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            stall_hold = !stall_hold;
            if (stall_hold) stall_left = 1 + idle_gap();
            else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(100, 400);
            else stall_left = $urandom_range(1, 8);
         end
         stall_left--;
         rsp_stall <= stall_hold;
      end
   end

   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      directed_row_type   r;
      field_sample_type   s;
      rotated_sample_type want;
      logic [GNW-1:0] gain;
      logic [GRW-1:0] w, h;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_re   = '0;
      req_sample_im   = '0;
      req_col_index   = '0;
      req_row_index   = '0;
      req_step_number = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      cfg_gain        = '0;
      cfg_width       = knps_pkg::GRID_RESET;
      cfg_height      = knps_pkg::GRID_RESET;
      errors = 0; sent = 0; checked = 0; centre_hits = 0; settings = 0; calm_items = 0;

      // gain, width, height | re, im, col, row, step | typed | re, im, intensity, centre, step
      // zero samples under reset settings: centre sits at 512,512
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h0000, 16'h0000, 10'd512, 10'd512, 16'h0000},
                       1'b1, '{16'h0000, 16'h0000, 32'h0, 1'b1, 16'h0000}});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h0000, 16'h0000, 10'd1023, 10'd1023, 16'hFFFF},
                       1'b1, '{16'h0000, 16'h0000, 32'h0, 1'b0, 16'hFFFF}});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h7FFF, 16'h0000, 10'd0, 10'd0, 16'h0001}, 1'b0, '0});
      // most negative sample: full-scale intensity, rotated values saturate
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h8000, 16'h8000, 10'd512, 10'd512, 16'h0002}, 1'b0, '0});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h0000, 16'h8000, 10'd3, 10'd5, 16'h0003}, 1'b0, '0});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h7FFF, 16'h7FFF, 10'd511, 10'd512, 16'h0004}, 1'b0, '0});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h8000, 16'h7FFF, 10'd512, 10'd511, 16'h0005}, 1'b0, '0});
      rows.push_back('{32'h0000_0000, 11'd1024, 11'd1024,
                       '{16'h0001, 16'hFFFF, 10'd0, 10'd1023, 16'h0006}, 1'b0, '0});
      // unit intensity walks through each quadrant
      rows.push_back('{32'h4000_0000, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0010}, 1'b0, '0});
      rows.push_back('{32'h4000_0000, 11'd1024, 11'd1024,
                       '{16'h0000, 16'h4000, 10'd1, 10'd1, 16'h0011}, 1'b0, '0});
      rows.push_back('{32'h8000_0000, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0012}, 1'b0, '0});
      rows.push_back('{32'hC000_0000, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0013}, 1'b0, '0});
      // quadrant boundaries, including the wrap past a full turn
      rows.push_back('{32'h2000_0000, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0014}, 1'b0, '0});
      rows.push_back('{32'h1FFF_FFFF, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0015}, 1'b0, '0});
      rows.push_back('{32'hE000_0000, 11'd1024, 11'd1024,
                       '{16'h4000, 16'h0000, 10'd1, 10'd1, 16'h0016}, 1'b0, '0});
      rows.push_back('{32'hFFFF_FFFF, 11'd1024, 11'd1024,
                       '{16'h8000, 16'h8000, 10'd2, 10'd2, 16'h0017}, 1'b0, '0});
      rows.push_back('{32'hFFFF_FFFF, 11'd1024, 11'd1024,
                       '{16'h7FFF, 16'h8000, 10'd2, 10'd2, 16'h0018}, 1'b0, '0});
      // zero grid registers put the centre at the origin
      rows.push_back('{32'h0000_0000, 11'd0, 11'd0,
                       '{16'h0000, 16'h0000, 10'd0, 10'd0, 16'h0007},
                       1'b1, '{16'h0000, 16'h0000, 32'h0, 1'b1, 16'h0007}});
      // width above 1024 still halves plainly
      rows.push_back('{32'h0000_0000, 11'd2047, 11'd1,
                       '{16'h0000, 16'h0000, 10'd1023, 10'd0, 16'h8000},
                       1'b1, '{16'h0000, 16'h0000, 32'h0, 1'b1, 16'h8000}});
      // index outside a small grid is processed as usual
      rows.push_back('{32'h0123_4567, 11'd4, 11'd4,
                       '{16'h2EE0, 16'hEC78, 10'd1000, 10'd900, 16'h0100}, 1'b0, '0});
      rows.push_back('{32'h0123_4567, 11'd4, 11'd4,
                       '{16'h0000, 16'h0000, 10'd2, 10'd2, 16'h00FF},
                       1'b1, '{16'h0000, 16'h0000, 32'h0, 1'b1, 16'h00FF}});
      rows.push_back('{32'h1234_5678, 11'd1, 11'd1,
                       '{16'hFFFF, 16'h0001, 10'd0, 10'd0, 16'h0101}, 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < rows.size(); k++) begin
         r = rows[k];
         if (r.gain != cfg_gain || r.width != cfg_width || r.height != cfg_height)
            apply_config(r.gain, r.width, r.height, 1'b0);
         s = r.item;
         want = r.typed ? r.result : predict_rotation(s);
         send_sample(s, want);
      end

      for (int ph = 0; ph < 8; ph++) begin
         w = GRW'($urandom_range(1, 1024));
         h = GRW'($urandom_range(1, 1024));
         gain = $urandom;
         case (ph)
            0: begin gain = 32'hFFFF_FFFF; w = 11'd1024; h = 11'd1024; end
            1: begin w = 11'd0; h = 11'd0; end
            2: begin gain = 32'h0000_0001; w = 11'd2047; h = 11'd2047; end
            3: begin w = 11'd1; h = 11'd1; end
            4: gain = 32'h8000_0000;
            5: gain = $urandom_range(0, 65535);
            6: begin gain = 32'h0000_0000; w = 11'd1024; h = 11'd1; end
            default: begin w = 11'd2047; h = 11'd0; end
         endcase
         apply_config(gain, w, h, ph[0]);
         repeat (PHASE_ITEMS) begin
            s = random_sample();
            send_sample(s, predict_rotation(s));
         end
      end

      drain();
      repeat (LATENCY + 20) @(posedge clock);

      $display("%0d samples sent, %0d results checked across %0d register settings",
               sent, checked, settings);
      $display("%0d results flagged the grid centre, %0d mismatches", centre_hits, errors);
      if (errors == 0 && pending.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
